// File: rtl/core/pcbp_pkg.sv
// Shared constants, types and helper functions for the prefix code bit packer.
package pcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int LEN_W = 6;
	localparam int CODE_W = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;
	localparam int ACC_W = MAX_CODE_LEN + 7;
	localparam int CNT_W = $clog2(ACC_W + 1);
	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W = 8;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} entry_t;

	typedef struct packed {
		logic valid;
		logic flush;
	} item_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] res;
		res = len;
		if (len > LEN_W'(MAX_CODE_LEN)) begin
			res = LEN_W'(MAX_CODE_LEN);
		end
		return res;
	endfunction

	// Keeps only the low len bits of the code; lengths of 32 and above keep all.
	function automatic logic [CODE_W-1:0] mask_code(input logic [31:0] value,
			input logic [LEN_W-1:0] len);
		logic [32:0] mask;
		logic [31:0] masked;
		mask = (33'd1 << len) - 33'd1;
		masked = value & mask[31:0];
		return masked[CODE_W-1:0];
	endfunction

endpackage

// File: rtl/core/pcbp_if.sv
// Handshake interfaces for command items and packed byte items.
interface pcbp_cmd_if import pcbp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [7:0]        symbol;
	logic [31:0]       code_value;
	logic [LEN_W-1:0]  code_length;

	modport source (output valid, operation, symbol, code_value, code_length, input ready);
	modport sink (input valid, operation, symbol, code_value, code_length, output ready);
endinterface

interface pcbp_byte_if ();
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [3:0] valid_bits;
	logic       last;

	modport source (output valid, out_byte, valid_bits, last, input ready);
	modport sink (input valid, out_byte, valid_bits, last, output ready);
endinterface

// File: rtl/core/pcbp_code_table.sv
// Code table memory with synchronous read and per-entry valid bits.
module pcbp_code_table import pcbp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  entry_t            wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output entry_t            rd_data
);

	entry_t mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] written_q;
	entry_t rd_data_q;
	logic   rd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// An entry that was never loaded reads as length zero, code zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rd_hit_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_hit_q ? rd_data_q : '0;

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> written_q[$past(wr_addr)])
		else $error("written entry not marked valid");
	assert property (@(posedge clk) disable iff (!arst_n)
		!rd_hit_q |-> rd_data == '0)
		else $error("unwritten entry does not read as zero");
	assert property (@(posedge clk) disable iff (!arst_n)
		!rd_en |=> $stable(rd_hit_q))
		else $error("read result changed without a read");

endmodule

// File: rtl/core/pcbp_packer.sv
// Bit accumulator that merges codes and emits one packed byte per cycle while the output is not held by ready.
module pcbp_packer import pcbp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  item_t         item,
	input  entry_t        entry,
	output logic          take,
	pcbp_byte_if.source   pkd
);

	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovalid_q;
	logic [7:0]       obyte_q;
	logic [3:0]       obits_q;
	logic             olast_q;

	logic             out_free;
	logic             emit_enc;
	logic             emit_flush;
	logic [CNT_W-1:0] cnt_e;
	logic [ACC_W-1:0] acc_shr;
	logic [7:0]       flush_byte;

	assign out_free = !ovalid_q || pkd.ready;
	assign emit_enc = (cnt_q >= CNT_W'(8)) && out_free;
	assign cnt_e = emit_enc ? cnt_q - CNT_W'(8) : cnt_q;

	// A flush takes only when no full byte is pending, and needs the output
	// slot when it has bits to send. An encode merges as soon as the bits left
	// after this cycle's byte fit below one byte.
	always_comb begin
		take = 1'b0;
		if (item.valid) begin
			if (item.flush) begin
				take = (cnt_q < CNT_W'(8)) && ((cnt_q == '0) || out_free);
			end else begin
				take = cnt_e < CNT_W'(8);
			end
		end
	end

	assign emit_flush = take && item.flush && (cnt_q != '0);
	assign acc_shr = acc_q >> (cnt_q - CNT_W'(8));
	assign flush_byte = 8'(acc_q[7:0] << (4'd8 - cnt_q[3:0]));

	// Bits above the count are stale and never reach an output byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take && !item.flush) begin
				acc_q <= (acc_q << entry.len) | ACC_W'(entry.code);
				cnt_q <= cnt_e + CNT_W'(entry.len);
			end else if (take) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_free) begin
			ovalid_q <= emit_enc || emit_flush;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_enc) begin
			obyte_q <= acc_shr[7:0];
			obits_q <= 4'd8;
			olast_q <= cnt_q < CNT_W'(16);
		end else if (emit_flush) begin
			obyte_q <= flush_byte;
			obits_q <= cnt_q[3:0];
			olast_q <= 1'b1;
		end
	end

	assign pkd.valid = ovalid_q;
	assign pkd.out_byte = obyte_q;
	assign pkd.valid_bits = obits_q;
	assign pkd.last = olast_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ACC_W))
		else $error("bit count exceeds accumulator width");
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_flush |=> pkd.valid && pkd.last && (pkd.valid_bits < 4'd8)
			&& (pkd.valid_bits != 4'd0) && (cnt_q == '0))
		else $error("flush byte malformed");
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_enc |=> pkd.valid && (pkd.valid_bits == 4'd8))
		else $error("encode byte malformed");
	assert property (@(posedge clk) disable iff (!arst_n)
		take && !item.flush |-> cnt_e < CNT_W'(8))
		else $error("merge while a full byte is still pending");

endmodule

// File: rtl/core/prefix_code_bit_packer.sv
// Prefix code bit packer: code table lookup, bit merging and byte output.
// Path: an encode item passes the lookup stage, the accumulator and the output register before its first byte appears.
// Throughput: one item per cycle for loads while the lookup stage can pass its item on;
// an encode waits in the lookup stage until the bits left in the accumulator fit below one
// byte, since the output register takes at most one byte per cycle and can be held by ready.
// Reset: pending bits and all table entries read as zero right after reset.
module prefix_code_bit_packer import pcbp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pcbp_cmd_if.sink    cmd,
	pcbp_byte_if.source pkd
);

	item_t  s1_q;
	entry_t entry;
	entry_t wr_data;
	logic   take;
	logic   accept;
	logic   is_enc;
	logic   is_flush;
	logic   is_load;

	assign cmd.ready = !s1_q.valid || take;
	assign accept = cmd.valid && cmd.ready;
	assign is_load = cmd.operation == OP_LOAD;
	assign is_enc = cmd.operation == OP_ENCODE;
	assign is_flush = cmd.operation == OP_FLUSH;

	assign wr_data.len = clamp_len(cmd.code_length);
	assign wr_data.code = mask_code(cmd.code_value, clamp_len(cmd.code_length));

	// Loads write the table at acceptance and never occupy the lookup stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
		end else if (accept) begin
			s1_q.valid <= is_enc || is_flush;
			s1_q.flush <= is_flush;
		end else if (take) begin
			s1_q.valid <= 1'b0;
		end
	end

	pcbp_code_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load),
		.wr_addr (cmd.symbol),
		.wr_data (wr_data),
		.rd_en   (accept && is_enc),
		.rd_addr (cmd.symbol),
		.rd_data (entry)
	);

	pcbp_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (s1_q),
		.entry  (entry),
		.take   (take),
		.pkd    (pkd)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		take |-> s1_q.valid)
		else $error("packer took an empty stage");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && s1_q.valid |-> take)
		else $error("lookup stage overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_q.valid && !take |=> s1_q.valid && $stable(s1_q.flush))
		else $error("waiting item lost from the lookup stage");

endmodule
